>>> src/json_key_value_extractor_top_macros.svh
// Assertion helpers shared by the RTL.
`ifndef JSON_KEY_VALUE_EXTRACTOR_TOP_MACROS_SVH
`define JSON_KEY_VALUE_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JKVE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JKVE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/jkve_pkg.sv
package jkve_pkg;

    localparam int MAX_KEY_CHARS = 16;
    localparam int WIN_DEPTH     = MAX_KEY_CHARS + 1;
    localparam int KEY_LEN_W     = 5;
    localparam int CNT_W         = 5;
    localparam int NUM_W         = 64;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int FIFO_DEPTH    = 4;
    localparam int PTR_W         = 2;
    localparam int FCNT_W        = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd3;

    // value modes
    localparam logic [1:0] MODE_STRING = 2'd0;
    localparam logic [1:0] MODE_SCALAR = 2'd1;
    localparam logic [1:0] MODE_BOOL   = 2'd2;
    localparam logic [1:0] MODE_NUMBER = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [7:0] TRUE_WORD  [4] = '{8'h74, 8'h72, 8'h75, 8'h65};
    localparam logic [7:0] FALSE_WORD [5] = '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_KEY_ABSENT = 4'd1,
        ST_NO_VALUE   = 4'd2,
        ST_NOT_STRING = 4'd3,
        ST_UNTERM     = 4'd4,
        ST_EMPTY      = 4'd5,
        ST_NOT_BOOL   = 4'd6,
        ST_NOT_NUMBER = 4'd7,
        ST_OVERFLOW   = 4'd8
    } status_t;

    typedef enum logic [5:0] {
        PH_SEARCH = 6'b000001,
        PH_COLON  = 6'b000010,
        PH_AFTER  = 6'b000100,
        PH_QUOTED = 6'b001000,
        PH_BARE   = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       value_byte;
        status_t          status;
        logic             bool_value;
        logic [NUM_W-1:0] number_value;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return (c == CH_COMMA) || (c == CH_RBRACE) || (c == CH_RBRACK) || is_ws(c);
    endfunction

    function automatic status_t judge(
        input logic [1:0]       mode,
        input logic             wm_true,
        input logic             wm_false,
        input logic [CNT_W-1:0] vlen,
        input logic             has_digit,
        input logic             ovf
    );
        status_t st;
        st = ST_OK;
        if (mode == MODE_BOOL) begin
            if (!((wm_true && vlen == CNT_W'(4)) || (wm_false && vlen == CNT_W'(5)))) begin
                st = ST_NOT_BOOL;
            end
        end else if (mode == MODE_NUMBER) begin
            if (!has_digit) begin
                st = ST_NOT_NUMBER;
            end else if (ovf) begin
                st = ST_OVERFLOW;
            end
        end
        return st;
    endfunction

endpackage

>>> src/json_key_value_extractor_top.sv
// JSON key/value extractor.
// Input channel (s_valid/s_ready): one text byte per item, s_end_of_text on the
// last byte of each text. Result channel (m_valid/m_ready): value byte items
// (m_result_kind 0) streamed as the value arrives, and one status item
// (m_result_kind 1, m_last 1) after the last byte of every text.
// Configuration (cfg_we/cfg_index/cfg_data) loads the key, its length and the
// value mode; write only while no text is in flight.
// Each byte is handled in the cycle it is accepted: window compare, phase
// update and the decimal accumulate (x10 + digit) all settle combinationally,
// so one byte per cycle is sustained while s_ready is high. Results are
// registered into a 4-entry output queue and show on m_* behind earlier items.
// s_ready stays high while at least two queue slots are free; a stalled
// receiver fills the queue and then holds s_ready low until items drain.
// Reset (aresetn low, synchronous) empties the queue, restores the default
// configuration and starts a new text in the key search phase.
`include "json_key_value_extractor_top_macros.svh"

module json_key_value_extractor_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_text_byte,
    input  logic                           s_end_of_text,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_result_kind,
    output logic [7:0]                     m_value_byte,
    output logic [3:0]                     m_status,
    output logic                           m_bool_value,
    output logic [jkve_pkg::NUM_W-1:0]     m_number_value,
    output logic                           m_last,
    input  logic                           cfg_we,
    input  logic [jkve_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jkve_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jkve_pkg::*;

    // configuration
    logic [63:0]          key_low_reg;
    logic [63:0]          key_high_reg;
    logic [KEY_LEN_W-1:0] key_len_reg;
    logic [1:0]           mode_reg;

    // per-text state
    logic [7:0]       win_reg [WIN_DEPTH];
    logic [CNT_W-1:0] bytes_seen_reg, bytes_seen_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] vlen_reg, vlen_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic             digit_reg, digit_next;
    logic             ended_reg, ended_next;
    logic             ovf_reg, ovf_next;
    logic             wm_true_reg, wm_true_next;
    logic             wm_false_reg, wm_false_next;
    status_t          pend_reg, pend_next;

    // output queue
    result_t           fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;

    logic                 s_fire, m_fire;
    logic [127:0]         key_vec;
    logic [KEY_LEN_W-1:0] len_eff;
    logic [WIN_DEPTH-1:0] cand;
    logic                 token_hit;
    logic                 do_absorb, finish;
    logic [NUM_W+3:0]     mac;
    status_t              eot_status;
    result_t              byte_res, stat_res;
    logic [1:0]           push_cnt;

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign key_vec = {key_high_reg, key_low_reg};
    assign len_eff = (key_len_reg > KEY_LEN_W'(MAX_KEY_CHARS)) ?
                     KEY_LEN_W'(MAX_KEY_CHARS) : key_len_reg;

    // quoted key ending at the current byte, one candidate per key length
    always_comb begin
        for (int l = 0; l < WIN_DEPTH; l++) begin
            cand[l] = (win_reg[l] == CH_QUOTE);
            for (int i = 0; i < l; i++) begin
                cand[l] = cand[l] && (key_vec[8*i +: 8] == win_reg[l-1-i]);
            end
        end
    end

    assign token_hit = (s_text_byte == CH_QUOTE) &&
                       ({1'b0, bytes_seen_reg} >= ({1'b0, len_eff} + 6'd1)) &&
                       cand[len_eff];

    // acc * 10 + digit, carry-out above bit 63 flags overflow
    assign mac = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                 {64'd0, s_text_byte[3:0]};

    always_comb begin
        phase_next      = phase_reg;
        bytes_seen_next = bytes_seen_reg;
        vlen_next       = vlen_reg;
        acc_next        = acc_reg;
        digit_next      = digit_reg;
        ended_next      = ended_reg;
        ovf_next        = ovf_reg;
        wm_true_next    = wm_true_reg;
        wm_false_next   = wm_false_reg;
        pend_next       = pend_reg;
        do_absorb       = 1'b0;
        finish          = 1'b0;

        unique case (phase_reg)
            PH_SEARCH: begin
                if (token_hit) begin
                    phase_next = PH_COLON;
                end
                if (bytes_seen_reg != {CNT_W{1'b1}}) begin
                    bytes_seen_next = bytes_seen_reg + 1'b1;
                end
            end
            PH_COLON: begin
                if (s_text_byte == CH_COLON) begin
                    phase_next = PH_AFTER;
                end else if (!is_ws(s_text_byte)) begin
                    pend_next  = ST_NO_VALUE;
                    phase_next = PH_DONE;
                end
            end
            PH_AFTER: begin
                if (!is_ws(s_text_byte)) begin
                    if (s_text_byte == CH_QUOTE) begin
                        phase_next = PH_QUOTED;
                    end else if (mode_reg == MODE_STRING) begin
                        pend_next  = ST_NOT_STRING;
                        phase_next = PH_DONE;
                    end else if (is_term(s_text_byte)) begin
                        pend_next  = ST_EMPTY;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_BARE;
                        do_absorb  = 1'b1;
                    end
                end
            end
            PH_QUOTED: begin
                if (s_text_byte == CH_QUOTE) begin
                    finish = 1'b1;
                end else begin
                    do_absorb = 1'b1;
                end
            end
            PH_BARE: begin
                if (is_term(s_text_byte)) begin
                    finish = 1'b1;
                end else begin
                    do_absorb = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (do_absorb) begin
            if (vlen_reg >= CNT_W'(4) || TRUE_WORD[vlen_reg[1:0]] != s_text_byte) begin
                wm_true_next = 1'b0;
            end
            if (vlen_reg >= CNT_W'(5) || FALSE_WORD[vlen_reg[2:0]] != s_text_byte) begin
                wm_false_next = 1'b0;
            end
            if (vlen_reg != {CNT_W{1'b1}}) begin
                vlen_next = vlen_reg + 1'b1;
            end
            if (!ended_reg) begin
                if (s_text_byte >= CH_ZERO && s_text_byte <= CH_NINE) begin
                    digit_next = 1'b1;
                    if (!ovf_reg) begin
                        if (|mac[NUM_W+3:NUM_W]) begin
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = mac[NUM_W-1:0];
                        end
                    end
                end else begin
                    ended_next = 1'b1;
                end
            end
        end

        if (finish) begin
            pend_next  = judge(mode_reg, wm_true_next, wm_false_next, vlen_next,
                               digit_next, ovf_next);
            phase_next = PH_DONE;
        end

        unique case (phase_next)
            PH_SEARCH: eot_status = ST_KEY_ABSENT;
            PH_COLON,
            PH_AFTER:  eot_status = ST_NO_VALUE;
            PH_QUOTED: eot_status = ST_UNTERM;
            PH_BARE:   eot_status = judge(mode_reg, wm_true_next, wm_false_next, vlen_next,
                                          digit_next, ovf_next);
            default:   eot_status = pend_next;
        endcase
    end

    always_comb begin
        byte_res              = '0;
        byte_res.kind         = 1'b0;
        byte_res.value_byte   = s_text_byte;
        byte_res.status       = ST_OK;

        stat_res              = '0;
        stat_res.kind         = 1'b1;
        stat_res.status       = eot_status;
        stat_res.bool_value   = (eot_status == ST_OK) && (mode_reg == MODE_BOOL) &&
                                wm_true_next && (vlen_next == CNT_W'(4));
        stat_res.number_value = ((eot_status == ST_OK) && (mode_reg == MODE_NUMBER)) ?
                                acc_next : '0;
    end

    assign push_cnt = s_fire ? ({1'b0, do_absorb} + {1'b0, s_end_of_text}) : 2'd0;
    assign fcnt_next = fcnt_reg + FCNT_W'(push_cnt) - FCNT_W'(m_fire);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KEY_LEN_W'(1);
            mode_reg     <= MODE_STRING;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LEN:  key_len_reg  <= cfg_data[KEY_LEN_W-1:0];
                REG_MODE:     mode_reg     <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    // search window; only entries below bytes_seen are ever compared
    always_ff @(posedge aclk) begin
        if (s_fire && phase_reg == PH_SEARCH) begin
            win_reg[0] <= s_text_byte;
            for (int k = 1; k < WIN_DEPTH; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (s_fire && s_end_of_text)) begin
            phase_reg      <= PH_SEARCH;
            bytes_seen_reg <= '0;
            vlen_reg       <= '0;
            acc_reg        <= '0;
            digit_reg      <= 1'b0;
            ended_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            wm_true_reg    <= 1'b1;
            wm_false_reg   <= 1'b1;
            pend_reg       <= ST_KEY_ABSENT;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            bytes_seen_reg <= bytes_seen_next;
            vlen_reg       <= vlen_next;
            acc_reg        <= acc_next;
            digit_reg      <= digit_next;
            ended_reg      <= ended_next;
            ovf_reg        <= ovf_next;
            wm_true_reg    <= wm_true_next;
            wm_false_reg   <= wm_false_next;
            pend_reg       <= pend_next;
        end
    end

    // output queue: up to two pushes per item (value byte, then status)
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (do_absorb) begin
                fifo_mem[wr_ptr_reg] <= byte_res;
                if (s_end_of_text) begin
                    fifo_mem[PTR_W'(wr_ptr_reg + 1'b1)] <= stat_res;
                end
            end else if (s_end_of_text) begin
                fifo_mem[wr_ptr_reg] <= stat_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fcnt_reg <= fcnt_next;
        end
    end

    assign s_ready        = (fcnt_reg <= FCNT_W'(FIFO_DEPTH - 2));
    assign m_valid        = (fcnt_reg != '0);
    assign m_result_kind  = fifo_mem[rd_ptr_reg].kind;
    assign m_value_byte   = fifo_mem[rd_ptr_reg].value_byte;
    assign m_status       = fifo_mem[rd_ptr_reg].status;
    assign m_bool_value   = fifo_mem[rd_ptr_reg].bool_value;
    assign m_number_value = fifo_mem[rd_ptr_reg].number_value;
    assign m_last         = fifo_mem[rd_ptr_reg].kind;

    `JKVE_ASSERT_NOW(a_fifo_bound, aclk, aresetn, 1'b1, fcnt_reg <= FCNT_W'(FIFO_DEPTH), "output queue overrun")
    `JKVE_ASSERT_NEXT(a_eot_restart, aclk, aresetn, s_fire && s_end_of_text, phase_reg == PH_SEARCH && bytes_seen_reg == '0, "text state not cleared after last byte")
    `JKVE_ASSERT_NEXT(a_eot_status, aclk, aresetn, s_fire && s_end_of_text, m_valid, "no status item queued after last byte")
    `JKVE_ASSERT_NOW(a_byte_phase, aclk, aresetn, s_fire && do_absorb, phase_next == PH_QUOTED || phase_next == PH_BARE, "value byte emitted outside a value")

endmodule

>>> dv/json_key_value_extractor_top_test.sv
`timescale 1ns / 100ps

module json_key_value_extractor_top_test;
    import jkve_pkg::*;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam int   TAIL_CYCLES = 4;
    localparam int   HOLD_CYCLES = 300;
    localparam int   RANDOM_BYTES = 1000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value_byte;
        status_t     status;
        logic        bool_value;
        logic [63:0] number_value;
        logic        last;
    } extract_t;

    typedef struct {
        string       key;
        int          key_len;
        logic [1:0]  mode;
        string       text;
        logic        pinned;
        status_t     st;
        logic        bval;
        logic [63:0] nval;
    } text_case_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte = 8'h00;
    logic        s_end_of_text = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_result_kind;
    logic [7:0]  m_value_byte;
    logic [3:0]  m_status;
    logic        m_bool_value;
    logic [63:0] m_number_value;
    logic        m_last;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #1 aclk = ~aclk;

    json_key_value_extractor_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_value_byte   (m_value_byte),
        .m_status       (m_status),
        .m_bool_value   (m_bool_value),
        .m_number_value (m_number_value),
        .m_last         (m_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // shadow configuration
    logic [63:0] key_lo = '0;
    logic [63:0] key_hi = '0;
    logic [4:0]  key_len = 5'd1;
    logic [1:0]  vmode = MODE_STRING;

    // shadow text state
    logic [7:0]  win [WIN_DEPTH];
    int          seen;
    phase_t      ph;
    int          vlen;
    logic [63:0] acc;
    logic        has_digit;
    logic        num_end;
    logic        num_ovf;
    logic        wm_true;
    logic        wm_false;
    status_t     held_status;

    extract_t    extraction_q [$];
    logic [7:0]  text_q [$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          random_bytes = 0;
    logic        long_hold_req = 1'b0;

    text_case_t text_cases [26] = '{
        '{"",  1, MODE_STRING, "{\"k\":1}",        1'b1, ST_KEY_ABSENT, 1'b0, 64'd0},
        '{"k", 1, MODE_STRING, "{\"k\":\"ab\"}",   1'b1, ST_OK,         1'b0, 64'd0},
        '{"k", 1, MODE_STRING, "{\"k\" :\t1}",     1'b1, ST_NOT_STRING, 1'b0, 64'd0},
        '{"k", 1, MODE_STRING, "{\"k\":\"ab",      1'b1, ST_UNTERM,     1'b0, 64'd0},
        '{"k", 1, MODE_STRING, "{\"k\"}",          1'b1, ST_NO_VALUE,   1'b0, 64'd0},
        '{"k", 1, MODE_STRING, "{\"k\":",          1'b1, ST_NO_VALUE,   1'b0, 64'd0},
        '{"k", 1, MODE_STRING, "{\"k\"",           1'b1, ST_NO_VALUE,   1'b0, 64'd0},
        '{"k", 1, MODE_STRING, "{\"k\":\"\"}",     1'b1, ST_OK,         1'b0, 64'd0},
        '{"k", 1, MODE_STRING, "{\"k\":\"\377\001\"}", 1'b0, ST_OK,     1'b0, 64'd0},
        '{"k", 1, MODE_SCALAR, "{\"k\":,}",        1'b1, ST_EMPTY,      1'b0, 64'd0},
        '{"k", 1, MODE_SCALAR, "{\"k\":abc ,\"z\":1}", 1'b0, ST_OK,     1'b0, 64'd0},
        '{"k", 1, MODE_SCALAR, "\"k\":\"x y\"",    1'b0, ST_OK,         1'b0, 64'd0},
        '{"k", 1, MODE_BOOL,   "{\"k\":true}",     1'b1, ST_OK,         1'b1, 64'd0},
        '{"k", 1, MODE_BOOL,   "{\"k\":false}",    1'b1, ST_OK,         1'b0, 64'd0},
        '{"k", 1, MODE_BOOL,   "{\"k\":\"true\"}", 1'b1, ST_OK,         1'b1, 64'd0},
        '{"k", 1, MODE_BOOL,   "{\"k\":tru}",      1'b1, ST_NOT_BOOL,   1'b0, 64'd0},
        '{"k", 1, MODE_BOOL,   "{\"k\":\"\"}",     1'b1, ST_NOT_BOOL,   1'b0, 64'd0},
        '{"k", 1, MODE_BOOL,   "{\"k\":truex}",    1'b1, ST_NOT_BOOL,   1'b0, 64'd0},
        '{"k", 1, MODE_NUMBER, "{\"k\":18446744073709551615}",
          1'b1, ST_OK, 1'b0, ALL_ONES},
        '{"k", 1, MODE_NUMBER, "{\"k\":18446744073709551616}",
          1'b1, ST_OVERFLOW, 1'b0, 64'd0},
        '{"k", 1, MODE_NUMBER, "{\"k\":-5}",       1'b1, ST_NOT_NUMBER, 1'b0, 64'd0},
        '{"k", 1, MODE_NUMBER, "{\"k\":12ab}",     1'b1, ST_OK,         1'b0, 64'd12},
        '{"k", 1, MODE_NUMBER, "{\"k\":0",         1'b1, ST_OK,         1'b0, 64'd0},
        '{"",  0, MODE_SCALAR, "x\"\":7}",         1'b0, ST_OK,         1'b0, 64'd0},
        '{"abcdefghijklmnop", 31, MODE_STRING, "\"abcdefghijklmnop\":\"z\"",
          1'b0, ST_OK, 1'b0, 64'd0},
        '{"abcdefghijklmnop", 16, MODE_NUMBER, "{\"abcdefghijklmnop\" : 7}",
          1'b1, ST_OK, 1'b0, 64'd7}
    };

    function automatic logic blank_byte(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic scalar_end(input logic [7:0] c);
        return c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK || blank_byte(c);
    endfunction

    function automatic int key_span();
        return (key_len > MAX_KEY_CHARS) ? MAX_KEY_CHARS : int'(key_len);
    endfunction

    function automatic logic [7:0] key_char(input int i);
        return (i < 8) ? key_lo[8*i +: 8] : key_hi[8*(i-8) +: 8];
    endfunction

    function automatic void clear_text();
        foreach (win[i]) win[i] = 8'h00;
        seen = 0;
        ph = PH_SEARCH;
        vlen = 0;
        acc = '0;
        has_digit = 1'b0;
        num_end = 1'b0;
        num_ovf = 1'b0;
        wm_true = 1'b1;
        wm_false = 1'b1;
        held_status = ST_KEY_ABSENT;
    endfunction

    // closing quote of the key: window holds the key reversed, opening quote behind it
    function automatic logic key_token_hit(input logic [7:0] c);
        int len;
        len = key_span();
        if (c != CH_QUOTE || seen < len + 1 || win[len] != CH_QUOTE) return 1'b0;
        for (int i = 0; i < len; i++)
            if (key_char(i) != win[len-1-i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void take_value_byte(input logic [7:0] c);
        logic [63:0] d;
        if (vlen >= 4 || c != TRUE_WORD[vlen]) wm_true = 1'b0;
        if (vlen >= 5 || c != FALSE_WORD[vlen]) wm_false = 1'b0;
        if (vlen < 31) vlen++;
        if (!num_end) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = 64'(c - CH_ZERO);
                has_digit = 1'b1;
                if (!num_ovf) begin
                    if (acc > (ALL_ONES - d) / 10) num_ovf = 1'b1;
                    else acc = acc * 10 + d;
                end
            end else begin
                num_end = 1'b1;
            end
        end
    endfunction

    function automatic status_t value_verdict();
        if (vmode == MODE_BOOL)
            return ((wm_true && vlen == 4) || (wm_false && vlen == 5)) ? ST_OK : ST_NOT_BOOL;
        if (vmode == MODE_NUMBER) begin
            if (!has_digit) return ST_NOT_NUMBER;
            if (num_ovf) return ST_OVERFLOW;
        end
        return ST_OK;
    endfunction

    function automatic void extract_step(input logic [7:0] c, input logic eot);
        extract_t r;
        status_t st;
        r = '{kind: KIND_BYTE, value_byte: c, status: ST_OK, bool_value: 1'b0,
              number_value: '0, last: 1'b0};
        case (ph)
            PH_SEARCH: begin
                if (key_token_hit(c)) ph = PH_COLON;
                for (int i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
                win[0] = c;
                if (seen < 31) seen++;
            end
            PH_COLON: begin
                if (c == CH_COLON) begin
                    ph = PH_AFTER;
                end else if (!blank_byte(c)) begin
                    held_status = ST_NO_VALUE;
                    ph = PH_DONE;
                end
            end
            PH_AFTER: begin
                if (!blank_byte(c)) begin
                    if (c == CH_QUOTE) begin
                        ph = PH_QUOTED;
                    end else if (vmode == MODE_STRING) begin
                        held_status = ST_NOT_STRING;
                        ph = PH_DONE;
                    end else if (scalar_end(c)) begin
                        held_status = ST_EMPTY;
                        ph = PH_DONE;
                    end else begin
                        ph = PH_BARE;
                        take_value_byte(c);
                        extraction_q.push_back(r);
                    end
                end
            end
            PH_QUOTED, PH_BARE: begin
                if ((ph == PH_QUOTED && c == CH_QUOTE) || (ph == PH_BARE && scalar_end(c))) begin
                    held_status = value_verdict();
                    ph = PH_DONE;
                end else begin
                    take_value_byte(c);
                    extraction_q.push_back(r);
                end
            end
            default: ;
        endcase
        if (eot) begin
            case (ph)
                PH_SEARCH:          st = ST_KEY_ABSENT;
                PH_COLON, PH_AFTER: st = ST_NO_VALUE;
                PH_QUOTED:          st = ST_UNTERM;
                PH_BARE:            st = value_verdict();
                default:            st = held_status;
            endcase
            r.kind = KIND_STATUS;
            r.value_byte = 8'h00;
            r.status = st;
            r.bool_value = st == ST_OK && vmode == MODE_BOOL && wm_true && vlen == 4;
            r.number_value = (st == ST_OK && vmode == MODE_NUMBER) ? acc : '0;
            r.last = 1'b1;
            extraction_q.push_back(r);
            clear_text();
        end
    endfunction

    // all tasks below are entered and left on a falling edge
    task automatic send_text(input logic pinned, input status_t pst, input logic pbool,
                             input logic [63:0] pnum);
        logic eot;
        foreach (text_q[i]) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 256)
                                                          : $urandom_range(1, 16);
            end
            eot = (i == text_q.size() - 1);
            s_valid <= 1'b1;
            s_text_byte <= text_q[i];
            s_end_of_text <= eot;
            do @(posedge aclk); while (!s_ready);
            extract_step(text_q[i], eot);
            if (eot && pinned) begin
                extraction_q[$].status = pst;
                extraction_q[$].bool_value = pbool;
                extraction_q[$].number_value = pnum;
            end
            burst_left--;
            random_bytes++;
            @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (extraction_q.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] len, input logic [1:0] mode);
        cfg_we <= 1'b1;
        cfg_index <= REG_KEY_LOW;
        cfg_data <= lo;
        @(negedge aclk);
        cfg_index <= REG_KEY_HIGH;
        cfg_data <= hi;
        @(negedge aclk);
        cfg_index <= REG_KEY_LEN;
        cfg_data <= 64'(len);
        @(negedge aclk);
        cfg_index <= REG_MODE;
        cfg_data <= 64'(mode);
        @(negedge aclk);
        cfg_we <= 1'b0;
        key_lo = lo;
        key_hi = hi;
        key_len = len;
        vmode = mode;
    endtask

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic void put_key_token();
        text_q.push_back(CH_QUOTE);
        for (int i = 0; i < key_span(); i++) text_q.push_back(key_char(i));
        text_q.push_back(CH_QUOTE);
    endfunction

    function automatic void put_blanks();
        logic [7:0] blanks [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        repeat ($urandom_range(0, 2)) text_q.push_back(blanks[$urandom_range(0, 3)]);
    endfunction

    // mostly well-formed objects with random content, some noise and broken texts
    function automatic void build_text();
        string words [5] = '{"true", "false", "tru", "falsey", "nul"};
        string edges [3] = '{"18446744073709551615", "18446744073709551616",
                             "99999999999999999999"};
        string enders = ",}] ";
        int kind;
        int cut;
        logic quoted;
        logic [7:0] c;
        text_q.delete();
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 0) begin
                put_key_token();
                text_q.push_back(8'($urandom));
            end
            return;
        end
        push_str("{");
        if ($urandom_range(0, 3) == 0) push_str("\"q\":1,");
        put_key_token();
        put_blanks();
        if ($urandom_range(0, 19) == 0) text_q.push_back(8'($urandom_range(97, 122)));
        else text_q.push_back(CH_COLON);
        put_blanks();
        kind = $urandom_range(0, 4);
        if ($urandom_range(0, 9) < 6) begin
            case (vmode)
                MODE_STRING: kind = 0;
                MODE_SCALAR: kind = $urandom_range(0, 1);
                MODE_BOOL:   kind = 2;
                default:     kind = 3;
            endcase
        end
        quoted = (kind == 0) || ($urandom_range(0, 7) == 0);
        if (quoted) text_q.push_back(CH_QUOTE);
        case (kind)
            0: repeat ($urandom_range(0, 6)) begin
                c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                                : 8'($urandom_range(32, 126));
                text_q.push_back((c == CH_QUOTE) ? CH_ZERO : c);
            end
            1: repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(97, 122)));
            2: push_str(words[$urandom_range(0, 4)]);
            3: begin
                if ($urandom_range(0, 19) == 0) push_str("-");
                if ($urandom_range(0, 9) == 0) begin
                    push_str(edges[$urandom_range(0, 2)]);
                end else begin
                    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(15, 22)
                                                        : $urandom_range(1, 6))
                        text_q.push_back(8'($urandom_range(48, 57)));
                end
            end
            default: repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom));
        endcase
        if (quoted && $urandom_range(0, 9) != 0) text_q.push_back(CH_QUOTE);
        if ($urandom_range(0, 9) != 0) text_q.push_back(enders[$urandom_range(0, 3)]);
        if ($urandom_range(0, 3) == 0) push_str("\"z\":2}");
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, text_q.size());
            while (text_q.size() > cut) void'(text_q.pop_back());
        end
    endfunction

    initial begin : stimulus
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [1:0]  mode;
        logic [7:0]  c;
        int          phase_no;
        int          r;
        clear_text();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (text_cases[n]) begin
            lo = '0;
            hi = '0;
            for (int i = 0; i < text_cases[n].key.len(); i++) begin
                if (i < 8) lo[8*i +: 8] = text_cases[n].key[i];
                else hi[8*(i-8) +: 8] = text_cases[n].key[i];
            end
            len = 5'(text_cases[n].key_len);
            if (lo != key_lo || hi != key_hi || len != key_len || text_cases[n].mode != vmode)
            begin
                drain();
                load_config(lo, hi, len, text_cases[n].mode);
            end
            text_q.delete();
            push_str(text_cases[n].text);
            send_text(text_cases[n].pinned, text_cases[n].st, text_cases[n].bval,
                      text_cases[n].nval);
        end

        random_bytes = 0;
        phase_no = 0;
        while (random_bytes < RANDOM_BYTES) begin
            drain();
            for (int i = 0; i < 16; i++) begin
                c = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(97, 122)) : 8'($urandom);
                if (i < 8) lo[8*i +: 8] = c;
                else hi[8*(i-8) +: 8] = c;
            end
            r = $urandom_range(0, 99);
            len = (r < 60) ? 5'($urandom_range(1, 4)) :
                  (r < 75) ? 5'($urandom_range(5, 8)) :
                  (r < 85) ? 5'($urandom_range(9, 16)) :
                  (r < 92) ? 5'd0 : 5'($urandom_range(17, 31));
            mode = 2'($urandom_range(0, 3));
            case (phase_no)
                0: begin
                    lo = ALL_ONES;
                    hi = ALL_ONES;
                    len = 5'd16;
                    mode = MODE_NUMBER;
                end
                1: begin
                    lo = '0;
                    hi = '0;
                    len = 5'd2;
                    mode = MODE_STRING;
                end
                2: begin
                    len = 5'd31;
                    mode = MODE_BOOL;
                end
                default: ;
            endcase
            load_config(lo, hi, len, mode);
            // receiver backs off while this phase keeps offering items
            if (phase_no == 3) long_hold_req = 1'b1;
            repeat ((phase_no == 3) ? 12 : $urandom_range(3, 10)) begin
                build_text();
                send_text(1'b0, ST_OK, 1'b0, '0);
            end
            phase_no++;
        end
        drain();

        if (mismatch_count == 0) begin
            $display("json_key_value_extractor_top_test: done, clean");
        end else begin
            $display("json_key_value_extractor_top_test: done, errors");
        end
        $finish;
    end

    initial begin : receiver
        int style;
        int span;
        int tick;
        style = 0;
        span = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                long_hold_req = 1'b0;
            end else begin
                if (span == 0) begin
                    style = $urandom_range(0, 3);
                    span = $urandom_range(16, 96);
                end
                span--;
                tick++;
                case (style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 9) < 3);
                    default: m_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        extract_t want;
        if (aresetn && m_valid && m_ready) begin
            if (extraction_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d byte %02h status %0d last %0d",
                             m_result_kind, m_value_byte, m_status, m_last);
            end else begin
                want = extraction_q.pop_front();
                if (m_result_kind !== want.kind || m_value_byte !== want.value_byte ||
                    m_status !== want.status || m_bool_value !== want.bool_value ||
                    m_number_value !== want.number_value || m_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch (exp/act): kind %0d/%0d byte %02h/%02h ",
                                  "status %0d/%0d bool %0d/%0d number %0d/%0d last %0d/%0d"},
                                 want.kind, m_result_kind, want.value_byte, m_value_byte,
                                 want.status, m_status, want.bool_value, m_bool_value,
                                 want.number_value, m_number_value, want.last, m_last);
                end
            end
        end
    end

    initial begin : watchdog
        #1_000_000;
        $display("json_key_value_extractor_top_test: done, errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/jkve_pkg.sv
src/json_key_value_extractor_top.sv
dv/json_key_value_extractor_top_test.sv
